// ----- hdl/radix2_complex_fft_core_assert.svh -----
// assertion macros for the fft core checker
`ifndef RADIX2_COMPLEX_FFT_CORE_ASSERT_SVH
`define RADIX2_COMPLEX_FFT_CORE_ASSERT_SVH
// implication checked every clock, quiet during reset
`define R2F_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("r2f assertion failed");
// next-cycle implication
`define R2F_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("r2f assertion failed");
`endif

// ----- hdl/r2fft_pkg.sv -----
// ----------------------------------------------------------------------------
// r2fft_pkg
// types, constants and fixed-point helpers for the radix-2 fft core
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int unsigned POINTS_DEFAULT = 256;
  localparam int unsigned STORE_DEPTH    = 256;
  localparam int unsigned ADDR_W         = 8;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         index;
    logic signed [31:0] in_real;
    logic signed [31:0] in_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_real;
    logic signed [31:0] out_imag;
    logic [7:0]         out_index;
  } out_item_t;

  // classified command from front to back
  typedef struct packed {
    opcode_t            op;
    logic               in_range;
    logic [7:0]         index;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REV_RD,
    ST_REV_WAIT,
    ST_REV_WR,
    ST_BF_RD,
    ST_BF_WAIT,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WR,
    ST_TW_MUL,
    ST_TW_SUM,
    ST_READ_WAIT,
    ST_READ_OUT
  } eng_state_t;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  function automatic logic signed [31:0] seed_cos(input logic [3:0] s);
    logic signed [31:0] r;
    begin
      unique case (s)
        4'd1: r = -32'sd65536;
        4'd2: r = 32'sd0;
        4'd3: r = 32'sd46341;
        4'd4: r = 32'sd60547;
        4'd5: r = 32'sd64277;
        4'd6: r = 32'sd65220;
        4'd7: r = 32'sd65457;
        4'd8: r = 32'sd65516;
        default: r = 32'sd65516;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] seed_sin(input logic [3:0] s);
    logic signed [31:0] r;
    begin
      unique case (s)
        4'd1: r = 32'sd0;
        4'd2: r = 32'sd65536;
        4'd3: r = 32'sd46341;
        4'd4: r = 32'sd25080;
        4'd5: r = 32'sd12785;
        4'd6: r = 32'sd6424;
        4'd7: r = 32'sd3216;
        4'd8: r = 32'sd1608;
        default: r = 32'sd1608;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    begin
      if (v > 33'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -33'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
    end
  endfunction

  // round half up, floor shift, saturate
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [64:0] v;
    logic signed [48:0] s;
    logic signed [31:0] r;
    begin
      v = {p[63], p} + 65'sd32768;
      s = v[64:16];
      if (s > 49'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (s < -49'sh0_8000_0000) r = 32'sh8000_0000;
      else r = s[31:0];
      return r;
    end
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat33({a[31], a} + {b[31], b});
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat33({a[31], a} - {b[31], b});
  endfunction

endpackage

// ----- hdl/r2fft_front.sv -----
// ----------------------------------------------------------------------------
// r2fft_front
// accepts items, classifies them and queues commands for the engine
// ----------------------------------------------------------------------------
module r2fft_front #(
  parameter int unsigned POINTS = r2fft_pkg::POINTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  r2fft_pkg::in_item_t in_data,
  output logic               cmd_valid,
  input  logic               cmd_take,
  output r2fft_pkg::cmd_t    cmd
);
  import r2fft_pkg::*;

  cmd_t       q [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       c_in;

  assign in_stall  = (count == 2'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rd_ptr];

  always_comb begin
    c_in.op       = opcode_t'(in_data.opcode);
    c_in.in_range = ({1'b0, in_data.index} < 9'(POINTS));
    c_in.index    = in_data.index;
    c_in.re       = in_data.in_real;
    c_in.im       = in_data.in_imag;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= c_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hdl/r2fft_engine.sv -----
// ----------------------------------------------------------------------------
// r2fft_engine
// sample memory, bit reversal, butterfly datapath and bin read-out
// ----------------------------------------------------------------------------
module r2fft_engine #(
  parameter int unsigned POINTS = r2fft_pkg::POINTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                inverse_mode,
  input  logic                cmd_valid,
  output logic                cmd_take,
  input  r2fft_pkg::cmd_t     cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output r2fft_pkg::out_item_t out_data
);
  import r2fft_pkg::*;

  localparam int unsigned BITS =
    (POINTS >= 256) ? 8 : (POINTS >= 128) ? 7 : (POINTS >= 64) ? 6 :
    (POINTS >= 32) ? 5 : (POINTS >= 16) ? 4 : (POINTS >= 8) ? 3 :
    (POINTS >= 4) ? 2 : 1;
  localparam int unsigned LEN = 1 << BITS;

  logic [63:0] mem [STORE_DEPTH];
  logic [63:0] rd_data;
  logic [7:0]  rd_addr;
  logic        we;
  logic [7:0]  wr_addr;
  logic [63:0] wr_data;

  eng_state_t state, state_next;

  logic [8:0]  k;          // reversal index
  logic [3:0]  stage;
  logic [8:0]  half;
  logic [8:0]  base;
  logic [8:0]  j;
  logic signed [31:0] wr_c, wi_c, cr, ci;
  logic signed [31:0] ar, ai, br, bi;
  logic signed [63:0] p0, p1, p2, p3;
  logic signed [31:0] tr, ti;
  logic [1:0]  sub;        // sub-step for two reads / two writes
  logic [7:0]  out_idx_r;
  logic        out_zero;
  logic [7:0]  rev_k;
  logic [7:0]  i0, i1;

  always_comb begin
    rev_k = '0;
    for (int t = 0; t < BITS; t++) rev_k[BITS-1-t] = k[t];
  end

  assign i0 = 8'(base + j);
  assign i1 = 8'(base + j + half);

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state, command take, memory address and write select
  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    we         = 1'b0;
    wr_addr    = cmd.index;
    wr_data    = {cmd.re, cmd.im};
    rd_addr    = cmd.index;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && !out_valid) begin
          cmd_take = 1'b1;
          unique case (cmd.op)
            OP_WRITE: we = cmd.in_range;
            OP_RUN:   state_next = ST_REV_RD;
            OP_READ:  state_next = ST_READ_WAIT;
            OP_NONE:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_REV_RD: begin
        rd_addr = (sub == 2'd0) ? k[7:0] : rev_k;
        if (k == 9'(LEN)) state_next = ST_BF_RD;
        else if (k[7:0] >= rev_k) state_next = ST_REV_RD;
        else if (sub == 2'd1) state_next = ST_REV_WAIT;
      end
      ST_REV_WAIT: state_next = ST_REV_WR;
      ST_REV_WR: begin
        we      = 1'b1;
        wr_addr = (sub == 2'd0) ? rev_k : k[7:0];
        wr_data = (sub == 2'd0) ? {ar, ai} : {br, bi};
        if (sub == 2'd1) state_next = ST_REV_RD;
      end
      ST_BF_RD: begin
        rd_addr = (sub == 2'd0) ? i0 : i1;
        if (stage > 4'(BITS)) state_next = ST_IDLE;
        else if (sub == 2'd1) state_next = ST_BF_WAIT;
      end
      ST_BF_WAIT: state_next = ST_BF_MUL;
      ST_BF_MUL:  state_next = ST_BF_SUM;
      ST_BF_SUM:  state_next = ST_BF_WR;
      ST_BF_WR: begin
        we      = 1'b1;
        wr_addr = (sub == 2'd0) ? i0 : i1;
        wr_data = (sub == 2'd0) ? {qadd(ar, tr), qadd(ai, ti)}
                                : {qsub(ar, tr), qsub(ai, ti)};
        if (sub == 2'd1) state_next = ST_TW_MUL;
      end
      ST_TW_MUL: state_next = ST_TW_SUM;
      ST_TW_SUM: state_next = ST_BF_RD;
      ST_READ_WAIT: begin
        rd_addr    = out_idx_r;
        state_next = ST_READ_OUT;
      end
      ST_READ_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sub       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          sub <= 2'd0;
          k   <= '0;
          if (cmd_take && cmd.op == OP_READ) begin
            out_idx_r <= cmd.index;
            out_zero  <= !cmd.in_range;
          end
        end
        ST_REV_RD: begin
          if (k == 9'(LEN)) begin
            stage <= 4'd1;
            half  <= 9'd1;
            base  <= '0;
            j     <= '0;
            sub   <= 2'd0;
            cr    <= ONE_Q16;
            ci    <= '0;
            wr_c  <= seed_cos(4'd1);
            wi_c  <= inverse_mode ? seed_sin(4'd1) : qsub(32'sd0, seed_sin(4'd1));
          end else if (k[7:0] >= rev_k) begin
            k <= k + 9'd1;
          end else begin
            sub <= sub + 2'd1;
          end
          if (sub == 2'd1) {ar, ai} <= rd_data;
        end
        ST_REV_WAIT: begin
          {br, bi} <= rd_data;
          sub <= 2'd0;
        end
        ST_REV_WR: begin
          if (sub == 2'd1) begin
            sub <= 2'd0;
            k   <= k + 9'd1;
          end else begin
            sub <= 2'd1;
          end
        end
        ST_BF_RD: begin
          if (sub == 2'd1) {ar, ai} <= rd_data;
          sub <= (sub == 2'd1) ? 2'd0 : 2'd1;
        end
        ST_BF_WAIT: {br, bi} <= rd_data;
        ST_BF_MUL: begin
          p0 <= cr * br;
          p1 <= ci * bi;
          p2 <= cr * bi;
          p3 <= ci * br;
        end
        ST_BF_SUM: begin
          tr  <= qsub(qround(p0), qround(p1));
          ti  <= qadd(qround(p2), qround(p3));
          sub <= 2'd0;
        end
        ST_BF_WR: begin
          sub <= (sub == 2'd1) ? 2'd0 : 2'd1;
        end
        ST_TW_MUL: begin
          p0 <= wr_c * cr;
          p1 <= wi_c * ci;
          p2 <= wr_c * ci;
          p3 <= wi_c * cr;
        end
        ST_TW_SUM: begin
          sub <= 2'd0;
          if (j + 9'd1 < half) begin
            j  <= j + 9'd1;
            cr <= qsub(qround(p0), qround(p1));
            ci <= qadd(qround(p2), qround(p3));
          end else begin
            j  <= '0;
            cr <= ONE_Q16;
            ci <= '0;
            if (base + (half << 1) < 9'(LEN)) begin
              base <= base + (half << 1);
            end else begin
              base  <= '0;
              half  <= half << 1;
              stage <= stage + 4'd1;
              wr_c  <= seed_cos(stage + 4'd1);
              wi_c  <= inverse_mode ? seed_sin(stage + 4'd1)
                                    : qsub(32'sd0, seed_sin(stage + 4'd1));
            end
          end
        end
        ST_READ_OUT: begin
          out_valid          <= 1'b1;
          out_data.out_index <= out_idx_r;
          out_data.out_real  <= out_zero ? 32'sd0 : rd_data[63:32];
          out_data.out_imag  <= out_zero ? 32'sd0 : rd_data[31:0];
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/radix2_complex_fft_core.sv -----
// path: a write is queued, then written when the engine takes it; a read is queued, then
// addresses memory in ST_READ_WAIT and its bin is registered onto out_data in ST_READ_OUT
// transform: bit-reversed reorder swapping each pair once, then (len/2)*log2(len) butterflies
// throughput: one load per cycle while the queue has room, one read at a time until its
// result is taken, one engine op at a time; the sample memory sets the butterfly pace
// reset: synchronous, clears control and inverse_mode; sample memory undefined
// ----------------------------------------------------------------------------
// radix2_complex_fft_core
// in-place radix-2 dit fft with sample load and bin read transactions
// ----------------------------------------------------------------------------
module radix2_complex_fft_core #(
  parameter int unsigned POINTS = r2fft_pkg::POINTS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  r2fft_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output r2fft_pkg::out_item_t out_data
);
  import r2fft_pkg::*;

  logic inverse_mode;   // 0 forward, 1 unscaled inverse
  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) inverse_mode <= 1'b0;
    else if (cfg_we) inverse_mode <= cfg_data;
  end

  // front: takes each transaction and queues it
  r2fft_front #(.POINTS(POINTS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .cmd_valid, .cmd_take, .cmd
  );

  // back: memory, transform sequencer, read-out register
  r2fft_engine #(.POINTS(POINTS)) u_engine (
    .clk, .rst, .inverse_mode, .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .out_data
  );

endmodule

// ----- hdl/r2fft_checker.sv -----
// ----------------------------------------------------------------------------
// r2fft_assert_checker
// port-level checks for the fft core
// ----------------------------------------------------------------------------
`include "radix2_complex_fft_core_assert.svh"
module r2fft_assert_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input r2fft_pkg::out_item_t out_data
);

  `R2F_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `R2F_ASSERT_NXT(a_no_out_after_rst, $past(rst), !out_valid)
  `R2F_ASSERT_IMP(a_ready_after_rst, $past(rst), !in_stall)
endmodule

bind radix2_complex_fft_core r2fft_assert_checker u_assert (.*);

// ----- tb/sv/r2fft_checker.sv -----
// ----------------------------------------------------------------------------
// r2fft_checker
// watches the sample and bin channels, predicts every bin read with a local
// fixed-point fft model and compares each result transaction field by field
// ----------------------------------------------------------------------------
module r2fft_checker #(
  parameter int unsigned POINTS = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  r2fft_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  r2fft_pkg::out_item_t out_data,
  output int                   fail_count,
  output int                   pending,
  output int                   bins_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import r2fft_pkg::*;

  localparam int TW_COS [9] = '{0, -65536, 0, 46341, 60547, 64277, 65220, 65457, 65516};
  localparam int TW_SIN [9] = '{0, 0, 65536, 46341, 25080, 12785, 6424, 3216, 1608};

  int        spec_re [256];
  int        spec_im [256];
  logic      inv_mode;
  out_item_t bin_queue [$];

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // q16.16 product, round half up, floor shift
  function automatic int fx_mul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd32768;
    return clip32(p >>> 16);
  endfunction

  function automatic int fx_add(int a, int b);
    return clip32(longint'(a) + longint'(b));
  endfunction

  function automatic int fx_sub(int a, int b);
    return clip32(longint'(a) - longint'(b));
  endfunction

  function void run_fft();
    int len, nbits, rev, span, half, stg, wr, wi, cr, ci, nr, ni, tr, ti;
    int i0, i1, ar, ai, br, bi, tmp;
    len = 1;
    nbits = 0;
    while (len * 2 <= POINTS && len * 2 <= 256) begin
      len *= 2;
      nbits++;
    end
    // bit-reversed reorder
    for (int k = 0; k < len; k++) begin
      rev = 0;
      for (int t = 0; t < nbits; t++)
        if (k[t]) rev |= 1 << (nbits - 1 - t);
      if (k < rev) begin
        tmp = spec_re[k]; spec_re[k] = spec_re[rev]; spec_re[rev] = tmp;
        tmp = spec_im[k]; spec_im[k] = spec_im[rev]; spec_im[rev] = tmp;
      end
    end
    stg = 1;
    for (span = 2; span <= len; span *= 2) begin
      wr = TW_COS[stg > 8 ? 8 : stg];
      wi = TW_SIN[stg > 8 ? 8 : stg];
      if (!inv_mode) wi = fx_sub(0, wi);
      half = span / 2;
      for (int base = 0; base < len; base += span) begin
        cr = 65536;
        ci = 0;
        for (int k = 0; k < half; k++) begin
          i0 = (base + k) & 255;
          i1 = (i0 + half) & 255;
          ar = spec_re[i0]; ai = spec_im[i0];
          br = spec_re[i1]; bi = spec_im[i1];
          tr = fx_sub(fx_mul(cr, br), fx_mul(ci, bi));
          ti = fx_add(fx_mul(cr, bi), fx_mul(ci, br));
          spec_re[i0] = fx_add(ar, tr); spec_im[i0] = fx_add(ai, ti);
          spec_re[i1] = fx_sub(ar, tr); spec_im[i1] = fx_sub(ai, ti);
          nr = fx_sub(fx_mul(wr, cr), fx_mul(wi, ci));
          ni = fx_add(fx_mul(wr, ci), fx_mul(wi, cr));
          cr = nr;
          ci = ni;
        end
      end
      stg++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      inv_mode = 1'b0;
      bin_queue.delete();
      fail_count = 0;
      bins_checked = 0;
    end else begin
      if (cfg_we) inv_mode = cfg_data;
      if (in_valid && !in_stall) begin
        case (in_data.opcode)
          OP_WRITE: begin
            if (in_data.index < POINTS) begin
              spec_re[in_data.index] = in_data.in_real;
              spec_im[in_data.index] = in_data.in_imag;
            end
          end
          OP_RUN: run_fft();
          OP_READ: begin
            want.out_index = in_data.index;
            want.out_real = (in_data.index < POINTS) ? spec_re[in_data.index] : 0;
            want.out_imag = (in_data.index < POINTS) ? spec_im[in_data.index] : 0;
            bin_queue.push_back(want);
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        bins_checked++;
        if (bin_queue.size() == 0) begin
          $display("%t unexpected bin transaction: expected none actual %h", $time,
                   out_data);
          fail_count++;
        end else begin
          want = bin_queue.pop_front();
          if (out_data.out_real !== want.out_real) begin
            $display("%t out_real mismatch bin %0d: expected %h actual %h", $time,
                     want.out_index, want.out_real, out_data.out_real);
            fail_count++;
          end
          if (out_data.out_imag !== want.out_imag) begin
            $display("%t out_imag mismatch bin %0d: expected %h actual %h", $time,
                     want.out_index, want.out_imag, out_data.out_imag);
            fail_count++;
          end
          if (out_data.out_index !== want.out_index) begin
            $display("%t out_index mismatch: expected %h actual %h", $time,
                     want.out_index, out_data.out_index);
            fail_count++;
          end
        end
      end
    end
    pending = bin_queue.size();
  end

endmodule

// ----- tb/sv/tb_radix2_complex_fft_core.sv -----
// ----------------------------------------------------------------------------
// tb_radix2_complex_fft_core
// loads full sample frames, runs forward and inverse transforms and reads bins
// back under random gaps and stalls; checking lives in r2fft_checker
// ----------------------------------------------------------------------------
module tb_radix2_complex_fft_core;
  timeunit 1ns;
  timeprecision 1ps;
  import r2fft_pkg::*;

  localparam int unsigned NPTS      = 256;
  localparam int          IDLE_MAX  = 60000;  // covers a full transform plus a long hold-off
  localparam int          NFRAMES   = 5;

  logic      clk;
  logic      rst;
  logic      cfg_we;
  logic      cfg_data;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int fail_count, pending, bins_checked;
  int idle_cycles;
  int sent_items;
  bit hold_req;          // asks the bin receiver for one long hold-off
  bit loaded [NPTS];     // entries written since reset, never read otherwise

  radix2_complex_fft_core #(.POINTS(NPTS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  r2fft_checker #(.POINTS(NPTS)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .bins_checked (bins_checked)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: too long with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // bin receiver: bursts of ready, short stalls, rare long stalls, one forced hold-off
  initial begin
    int pick;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (500) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(0, 20)) @(posedge clk);
        end else if (pick < 9) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(0, 2)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end
      end
    end
  end

  // sample value: style 0 mixed, style 1 rails, zero and minus one only
  function automatic logic [31:0] pick_sample(int style);
    int sel;
    sel = (style == 1) ? 0 : $urandom_range(0, 9);
    case (sel)
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return $urandom();
      default: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
    endcase
  endfunction

  // one transaction with a random lead-in gap; valid stays up when no gap
  task automatic push_cmd(opcode_t op, logic [7:0] idx, logic [31:0] re, logic [31:0] im);
    int gap;
    case ($urandom_range(0, 19))
      0: gap = $urandom_range(10, 40);
      1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{opcode: op, index: idx, in_real: re, in_imag: im};
    do @(posedge clk); while (in_stall);
    sent_items++;
    if (op == OP_WRITE) loaded[idx] = 1'b1;
  endtask

  task automatic read_loaded_bin();
    int idx;
    do idx = $urandom_range(0, NPTS - 1); while (!loaded[idx]);
    push_cmd(OP_READ, 8'(idx), $urandom(), $urandom());
  endtask

  // register writes only with nothing in flight
  task automatic set_inverse(logic mode);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int order [NPTS];
    int j, tmp, style, nreads;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_req = 1'b0;
    sent_items = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: rails, zero, ignored opcode, read back, overwrite
    set_inverse(1'b0);
    push_cmd(OP_WRITE, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    push_cmd(OP_WRITE, 8'd255, 32'h8000_0000, 32'h7FFF_FFFF);
    push_cmd(OP_WRITE, 8'd1, 32'h0, 32'h0);
    push_cmd(OP_WRITE, 8'd128, 32'hFFFF_FFFF, 32'h0001_0000);
    push_cmd(OP_NONE, 8'd7, 32'h1234_5678, 32'h9ABC_DEF0);
    push_cmd(OP_READ, 8'd0, 32'h0, 32'h0);
    push_cmd(OP_READ, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(OP_READ, 8'd1, 32'h0, 32'h0);
    push_cmd(OP_READ, 8'd128, 32'h0, 32'h0);
    push_cmd(OP_NONE, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(OP_WRITE, 8'd0, 32'h0000_0001, 32'hFFFF_FFFE);
    push_cmd(OP_READ, 8'd0, 32'h0, 32'h0);
    push_cmd(OP_READ, 8'd255, 32'h0, 32'h0);

    // frames: full load with noise, transform, bin reads, and in frame 2 a second transform
    for (int f = 0; f < NFRAMES; f++) begin
      set_inverse(1'(f % 2));
      style = (f == NFRAMES - 1) ? 1 : 0;
      for (int k = 0; k < NPTS; k++) order[k] = k;
      for (int k = NPTS - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp = order[k]; order[k] = order[j]; order[j] = tmp;
      end
      for (int k = 0; k < NPTS; k++) begin
        push_cmd(OP_WRITE, 8'(order[k]), pick_sample(style), pick_sample(style));
        case ($urandom_range(0, 19))
          0, 1: read_loaded_bin();
          2: push_cmd(OP_NONE, 8'($urandom()), $urandom(), $urandom());
          3: push_cmd(OP_WRITE, 8'(order[$urandom_range(0, k)]), pick_sample(style),
                      pick_sample(style));
          default: ;
        endcase
      end
      push_cmd(OP_RUN, 8'($urandom()), $urandom(), $urandom());
      // the receiver sits out while reads pile up behind the transform
      if (f == 1) hold_req = 1'b1;
      nreads = $urandom_range(30, 50);
      for (int k = 0; k < nreads; k++) read_loaded_bin();
      if (f == 2) begin
        push_cmd(OP_RUN, 8'd0, 32'h0, 32'h0);
        for (int k = 0; k < 16; k++) read_loaded_bin();
      end
    end

    // drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d transactions over %0d frames, %0d bins checked", sent_items,
             NFRAMES, bins_checked);
    $display("forward and inverse transforms, rail values, long receiver hold-off");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/r2fft_pkg.sv
hdl/r2fft_front.sv
hdl/r2fft_engine.sv
hdl/radix2_complex_fft_core.sv
hdl/r2fft_checker.sv
tb/sv/r2fft_checker.sv
tb/sv/tb_radix2_complex_fft_core.sv
